// ===== rtl/prph_pkg.sv =====
package prph_pkg;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [1:0] MODE_1B = 2'd0;
  localparam logic [1:0] MODE_2B = 2'd1;
  localparam logic [1:0] MODE_4B = 2'd2;
  localparam logic [1:0] MODE_8B = 2'd3;

  localparam logic [3:0] CFG_MODE      = 4'd0;
  localparam logic [3:0] CFG_ROW_WIDTH = 4'd1;
  localparam logic [3:0] CFG_TILE_ROWS = 4'd2;
  localparam logic [3:0] CFG_COEF_N    = 4'd3;
  localparam logic [3:0] CFG_COEF_NW   = 4'd4;
  localparam logic [3:0] CFG_COEF_NE   = 4'd5;
  localparam logic [3:0] CFG_COEF_NN   = 4'd6;
  localparam logic [3:0] CFG_SHIFT     = 4'd7;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] sample_value;
    logic [2:0]  plane_select;
    logic [7:0]  bin_select;
  } req_t;

  typedef struct packed {
    logic [1:0]  resp_kind;
    logic [63:0] zigzag_residual;
    logic        sample_counted;
    logic [31:0] bin_count;
  } resp_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] plane;
    logic [7:0] bin;
    logic       counted;
    logic [1:0] mode;
  } meta_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_SWEEP = 2'b10
  } sweep_state_t;

endpackage

// ===== rtl/predictor_residual_plane_histogram.sv =====
// A request's response is registered once it has passed stages s1 to s5.
// Throughput: one request per cycle unless the response stalls or a clear
// or sweep holds the pipe; prediction, residual and the per-plane histogram
// read-modify-write are pipelined around the line and bin memories. A clear
// request waits in stage 5 while all bins are zeroed; after synchronous reset
// that pass runs before the first request. Configuration writes are always taken.
module predictor_residual_plane_histogram #(
  parameter int MAX_WIDTH  = 1024,
  parameter int NUM_PLANES = 8,
  parameter int NUM_BINS   = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  prph_pkg::req_t       req,
  output logic                 resp_valid,
  input  logic                 resp_ready,
  output prph_pkg::resp_t      resp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [3:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int BW = $clog2(NUM_BINS);

  function automatic logic [63:0] mode_mask(input logic [1:0] m);
    logic [63:0] r;
    r = 64'd0;
    unique case (m)
      prph_pkg::MODE_1B: r = 64'h0000_0000_0000_00FF;
      prph_pkg::MODE_2B: r = 64'h0000_0000_0000_FFFF;
      prph_pkg::MODE_4B: r = 64'h0000_0000_FFFF_FFFF;
      default:           r = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] mode_planes(input logic [1:0] m);
    logic [3:0] r;
    r = 4'd8;
    unique case (m)
      prph_pkg::MODE_1B: r = 4'd2;
      prph_pkg::MODE_2B: r = 4'd2;
      prph_pkg::MODE_4B: r = 4'd4;
      default:           r = 4'd8;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] mul_coef(input logic [63:0] op, input logic [15:0] cf);
    logic [63:0] prod;
    logic [63:0] corr;
    prod = op * cf;
    corr = cf[15] ? (op << 16) : 64'd0;
    return prod - corr;
  endfunction

  // configuration
  logic [1:0]  mode;
  logic [10:0] row_width;
  logic [15:0] tile_rows;
  logic [15:0] coef_n, coef_nw, coef_ne, coef_nn;
  logic [3:0]  pred_shift;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= prph_pkg::MODE_1B;
      row_width  <= 11'd1024;
      tile_rows  <= 16'd1024;
      coef_n     <= 16'd1;
      coef_nw    <= 16'hFFFF;
      coef_ne    <= 16'd0;
      coef_nn    <= 16'd0;
      pred_shift <= 4'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        prph_pkg::CFG_MODE:      mode       <= cfg_data[1:0];
        prph_pkg::CFG_ROW_WIDTH: row_width  <= cfg_data[10:0];
        prph_pkg::CFG_TILE_ROWS: tile_rows  <= cfg_data;
        prph_pkg::CFG_COEF_N:    coef_n     <= cfg_data;
        prph_pkg::CFG_COEF_NW:   coef_nw    <= cfg_data;
        prph_pkg::CFG_COEF_NE:   coef_ne    <= cfg_data;
        prph_pkg::CFG_COEF_NN:   coef_nn    <= cfg_data;
        prph_pkg::CFG_SHIFT:     pred_shift <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  prph_pkg::sweep_state_t state;
  logic [BW-1:0] sweep_cnt;
  logic          clr_done;
  logic          clear_wait;
  logic          advance;
  logic          accept;

  logic          s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  prph_pkg::meta_t s1_meta, s2_meta, s3_meta, s4_meta, s5_meta;

  assign clear_wait = s5_valid && (s5_meta.kind == prph_pkg::REQ_CLEAR) && !clr_done;
  assign advance    = (!resp_valid || resp_ready) && (state == prph_pkg::ST_RUN) && !clear_wait;
  assign req_ready  = advance;
  assign accept     = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= prph_pkg::ST_SWEEP;
      sweep_cnt <= '0;
      clr_done  <= 1'b0;
    end else begin
      unique case (state)
        prph_pkg::ST_RUN: begin
          if (advance) clr_done <= 1'b0;
          if (clear_wait) begin
            state     <= prph_pkg::ST_SWEEP;
            sweep_cnt <= '0;
          end
        end
        prph_pkg::ST_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == BW'(NUM_BINS - 1)) begin
            state    <= prph_pkg::ST_RUN;
            clr_done <= 1'b1;
          end
        end
        default: state <= prph_pkg::ST_RUN;
      endcase
    end
  end

  // raster position
  logic [31:0]   rw32, ew32;
  logic [CW-1:0] ew;
  logic [AW-1:0] col, col_next, c_cur;
  logic [15:0]   row, row_cur, row_next;
  logic [63:0]   left;
  logic [CW-1:0] c_inc;
  logic          wrap, col_end;
  logic [63:0]   x_in, w_in, in_mask;
  logic          counted_in;

  always_comb begin
    rw32 = 32'(row_width);
    if (rw32 == 32'd0) ew32 = 32'd1;
    else if (rw32 > 32'(MAX_WIDTH)) ew32 = 32'(MAX_WIDTH);
    else ew32 = rw32;
    ew = ew32[CW-1:0];
    wrap = CW'(col) >= ew;
    c_cur = wrap ? '0 : col;
    row_cur = (wrap && row != 16'hFFFF) ? row + 16'd1 : row;
    c_inc = CW'(c_cur) + CW'(1);
    col_end = c_inc >= ew;
    col_next = col_end ? '0 : c_inc[AW-1:0];
    row_next = (col_end && row_cur != 16'hFFFF) ? row_cur + 16'd1 : row_cur;
    in_mask = mode_mask(mode);
    x_in = req.sample_value & in_mask;
    w_in = (c_cur != '0) ? (left & in_mask) : 64'd0;
    counted_in = (ew >= CW'(3)) && (tile_rows >= 16'd3) && (row_cur < tile_rows);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      left <= '0;
    end else if (accept) begin
      case (req.req_type)
        prph_pkg::REQ_SAMPLE: begin
          col  <= col_next;
          row  <= row_next;
          left <= x_in;
        end
        prph_pkg::REQ_CLEAR: begin
          col  <= '0;
          row  <= '0;
          left <= '0;
        end
        default: ;
      endcase
    end
  end

  // stage 1: line buffer data and products
  logic [63:0]   above_mem [MAX_WIDTH];
  logic [63:0]   two_mem   [MAX_WIDTH];
  logic [63:0]   ra_rd0, ra_rd1, rt_rd;
  logic [63:0]   s1_x, s1_w;
  logic [AW-1:0] s1_c, s1_c1;
  logic          s1_has_n, s1_has_nw, s1_has_ne, s1_has_nn;
  logic          llw_v;
  logic [AW-1:0] llw_addr;
  logic [63:0]   llw_x, llw_ra;
  logic [63:0]   nw_hold;
  logic [63:0]   ra_c, ra_c1, rt_c, s1_mask;
  logic [63:0]   op_n, op_nw, op_ne, op_nn;
  logic          s1_sample;
  prph_pkg::meta_t meta_in;

  always_comb begin
    meta_in.kind    = req.req_type;
    meta_in.plane   = req.plane_select;
    meta_in.bin     = req.bin_select;
    meta_in.counted = counted_in;
    meta_in.mode    = mode;
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (advance) s1_valid <= accept;
  end

  always_ff @(posedge clk) begin
    if (advance && accept) begin
      s1_meta   <= meta_in;
      s1_x      <= x_in;
      s1_w      <= w_in;
      s1_c      <= c_cur;
      s1_c1     <= c_inc[AW-1:0];
      s1_has_n  <= row_cur != 16'd0;
      s1_has_nw <= (row_cur != 16'd0) && (c_cur != '0);
      s1_has_ne <= (row_cur != 16'd0) && !col_end;
      s1_has_nn <= row_cur >= 16'd2;
    end
  end

  assign s1_sample = s1_valid && (s1_meta.kind == prph_pkg::REQ_SAMPLE);

  always_comb begin
    s1_mask = mode_mask(s1_meta.mode);
    ra_c  = (llw_v && llw_addr == s1_c)  ? llw_x  : ra_rd0;
    ra_c1 = (llw_v && llw_addr == s1_c1) ? llw_x  : ra_rd1;
    rt_c  = (llw_v && llw_addr == s1_c)  ? llw_ra : rt_rd;
    op_n  = s1_has_n  ? (ra_c & s1_mask)    : 64'd0;
    op_nw = s1_has_nw ? (nw_hold & s1_mask) : 64'd0;
    op_ne = s1_has_ne ? (ra_c1 & s1_mask)   : 64'd0;
    op_nn = s1_has_nn ? (rt_c & s1_mask)    : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (advance && s1_sample) begin
      above_mem[s1_c] <= s1_x;
      two_mem[s1_c]   <= ra_c;
      nw_hold         <= ra_c;
    end
    if (accept && req.req_type == prph_pkg::REQ_SAMPLE) begin
      ra_rd0 <= above_mem[c_cur];
      ra_rd1 <= above_mem[c_inc[AW-1:0]];
      rt_rd  <= two_mem[c_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) llw_v <= 1'b0;
    else if (advance) llw_v <= s1_sample;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      llw_addr <= s1_c;
      llw_x    <= s1_x;
      llw_ra   <= ra_c;
    end
  end

  // stage 2: sum of products
  logic [63:0] s2_x, s2_w, s2_pn, s2_pnw, s2_pne, s2_pnn;
  logic [63:0] rnd;
  logic [63:0] s3_acc, s3_x, s3_w;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_meta <= s1_meta;
      s2_x    <= s1_x;
      s2_w    <= s1_w;
      s2_pn   <= mul_coef(op_n, coef_n);
      s2_pnw  <= mul_coef(op_nw, coef_nw);
      s2_pne  <= mul_coef(op_ne, coef_ne);
      s2_pnn  <= mul_coef(op_nn, coef_nn);
    end
  end

  assign rnd = (pred_shift != 4'd0) ? (64'd1 << (pred_shift - 4'd1)) : 64'd0;

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_meta <= s2_meta;
      s3_x    <= s2_x;
      s3_w    <= s2_w;
      s3_acc  <= s2_pn + s2_pnw + s2_pne + s2_pnn + rnd;
    end
  end

  // stage 3: residual and zigzag
  logic [63:0] k_val, res, zz, s3_mask, s4_zz, s5_zz;
  logic        res_sign;

  always_comb begin
    s3_mask = mode_mask(s3_meta.mode);
    k_val = 64'($signed(s3_acc) >>> pred_shift);
    res = (s3_x - s3_w - k_val) & s3_mask;
    unique case (s3_meta.mode)
      prph_pkg::MODE_1B: res_sign = res[7];
      prph_pkg::MODE_2B: res_sign = res[15];
      prph_pkg::MODE_4B: res_sign = res[31];
      default:           res_sign = res[63];
    endcase
    zz = ((res << 1) ^ (res_sign ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0)) & s3_mask;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_meta <= s3_meta;
      s4_zz   <= zz;
      s5_meta <= s4_meta;
      s5_zz   <= s4_zz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  // stages 4 and 5: plane histogram read-modify-write
  logic [COUNT_BITS-1:0] hist_mem [NUM_PLANES][NUM_BINS];
  logic [COUNT_BITS-1:0] hist_rd  [NUM_PLANES];
  logic [COUNT_BITS-1:0] hv       [NUM_PLANES];
  logic [COUNT_BITS-1:0] hinc     [NUM_PLANES];
  logic [COUNT_BITS-1:0] hlw_d    [NUM_PLANES];
  logic [BW-1:0]         s4_haddr [NUM_PLANES];
  logic [BW-1:0]         s5_haddr [NUM_PLANES];
  logic [BW-1:0]         hlw_addr [NUM_PLANES];
  logic [NUM_PLANES-1:0] hwe, hlw_v;
  logic [3:0]            s5_planes;

  assign s5_planes = mode_planes(s5_meta.mode);

  for (genvar b = 0; b < NUM_PLANES; b++) begin : g_plane
    always_comb begin
      s4_haddr[b] = (s4_meta.kind == prph_pkg::REQ_READ) ? s4_meta.bin : s4_zz[8*b +: 8];
      hv[b] = (hlw_v[b] && hlw_addr[b] == s5_haddr[b]) ? hlw_d[b] : hist_rd[b];
      hinc[b] = (hv[b] == {COUNT_BITS{1'b1}}) ? hv[b] : hv[b] + 1'b1;
      hwe[b] = s5_valid && (s5_meta.kind == prph_pkg::REQ_SAMPLE) && s5_meta.counted &&
               (32'(b) < 32'(s5_planes));
    end

    always_ff @(posedge clk) begin
      if (state == prph_pkg::ST_SWEEP) begin
        hist_mem[b][sweep_cnt] <= '0;
      end else if (advance && hwe[b]) begin
        hist_mem[b][s5_haddr[b]] <= hinc[b];
      end
      if (advance) begin
        hist_rd[b]  <= hist_mem[b][s4_haddr[b]];
        s5_haddr[b] <= s4_haddr[b];
        hlw_addr[b] <= s5_haddr[b];
        hlw_d[b]    <= hinc[b];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) hlw_v[b] <= 1'b0;
      else if (advance) hlw_v[b] <= hwe[b];
    end
  end

  // response
  logic [COUNT_BITS-1:0] bin_val;
  prph_pkg::resp_t       resp_next;

  always_comb begin
    bin_val = '0;
    for (int b = 0; b < NUM_PLANES; b++) begin
      if (s5_meta.plane == 3'(b)) bin_val = hv[b];
    end
    resp_next.resp_kind = s5_meta.kind;
    resp_next.zigzag_residual = (s5_meta.kind == prph_pkg::REQ_SAMPLE) ? s5_zz : 64'd0;
    resp_next.sample_counted = (s5_meta.kind == prph_pkg::REQ_SAMPLE) && s5_meta.counted;
    resp_next.bin_count = (s5_meta.kind == prph_pkg::REQ_READ) ? 32'(bin_val) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) resp_valid <= 1'b0;
    else if (advance) resp_valid <= s5_valid;
    else if (resp_ready) resp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (advance) resp <= resp_next;
  end

  a_sweep_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == prph_pkg::ST_SWEEP) |-> !req_ready)
    else $error("request taken during histogram sweep");

  a_clear_holds: assert property (@(posedge clk) disable iff (rst)
    clear_wait |=> (s5_valid && s5_meta.kind == prph_pkg::REQ_CLEAR))
    else $error("clear request left the pipe before its sweep");

  a_other_fields: assert property (@(posedge clk) disable iff (rst)
    (resp_valid && resp.resp_kind != prph_pkg::REQ_SAMPLE) |->
      (resp.zigzag_residual == 64'd0 && !resp.sample_counted))
    else $error("sample fields set on a non-sample response");

  a_line_fwd: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_sample) |=> (llw_v && llw_addr == $past(s1_c)))
    else $error("line buffer write not tracked for forwarding");

endmodule
